/* hdl/rmv_pkg.sv */
// shared types and constants for the running mean and variance block
// no dependencies; imported by rmv_div, rmv_dp, rmv_ctrl, the top level and the testbench
package rmv_pkg;

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 33;
  localparam int DIFF_W     = 34;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_SIMPLE,
    CMD_SQ_REC,
    CMD_SQ_REM,
    CMD_TOTAL,
    CMD_DIV,
    CMD_REC_SUM,
    CMD_REC_MEAN,
    CMD_REM_PREV,
    CMD_REM_FIN,
    CMD_POP_Q,
    CMD_POP_ZERO,
    CMD_SVAR_Q,
    CMD_SVAR_ZERO,
    CMD_OUT
  } cmd_e;

  typedef enum logic [2:0] {
    DS_D2_N,
    DS_M_N,
    DS_TOT_NM1,
    DS_SUM_CNT,
    DS_SUM_CNTM1
  } dsel_e;

  typedef struct packed {
    cmd_e  cmd;
    dsel_e dsel;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic div_done;
  } sts_t;

endpackage

/* hdl/rmv_div.sv */
// restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor
// depends on rmv_pkg
module rmv_div import rmv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quo_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  logic                  busy_q, done_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DIVISOR_W-1:0];

endmodule

/* hdl/rmv_dp.sv */
// datapath: statistics registers, squarer, count multiplier, shared divider
// depends on rmv_pkg and rmv_div
module rmv_dp import rmv_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] sample_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [31:0] count_o,
  output logic [31:0] mean_o,
  output logic [63:0] sum_sq_dev_o,
  output logic [63:0] pop_variance_o,
  output logic [63:0] sample_variance_o,
  output logic [1:0]  status_o
);

  localparam logic signed [DIVIDEND_W:0] SMAX =
    (65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1;
  localparam logic signed [DIVIDEND_W:0] SMIN = -SMAX - 65'sd1;

  op_e                     op_q;
  status_e                 status_q;
  logic [SAMPLE_BITS-1:0]  x_q, mean_q, prev_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic [63:0]             sum_q, d2_q, tot_q, pop_q, svar_q;
  logic [DIVISOR_W-1:0]    m_q;
  logic                    dneg_q, tneg_q;

  logic signed [DIFF_W-1:0] xs, ms, ps, diff;
  logic [DIFF_W-1:0]        dmag;
  logic [65:0]              sq;
  logic [DIVISOR_W-1:0]     cnt_x, nval, cnt_m1;
  logic signed [67:0]       nprod, tot;
  logic [63:0]              tmag, wsq;
  logic [64:0]              sum_add;
  logic signed [DIVIDEND_W:0] qs, qcl;
  logic signed [DIFF_W-1:0] q34, mean_new;

  logic                  div_start, div_done;
  logic [63:0]           div_a, quo;
  logic [DIVISOR_W-1:0]  div_b, rem;

  assign xs = DIFF_W'($signed(x_q));
  assign ms = DIFF_W'($signed(mean_q));
  assign ps = DIFF_W'($signed(prev_q));
  assign diff = xs - ((cmd_i.cmd == CMD_SQ_REM) ? ps : ms);
  assign dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sq = 66'(dmag[DIVISOR_W-1:0]) * 66'(dmag[DIVISOR_W-1:0]);

  assign cnt_x  = DIVISOR_W'(cnt_q);
  assign nval   = (op_q == OP_REMOVE) ? cnt_x : cnt_x + 1'b1;
  assign cnt_m1 = cnt_x - 1'b1;

  // count times mean, then less the sample, fits in 64 bits signed
  assign nprod = $signed({35'd0, cnt_x}) * 68'($signed(mean_q));
  assign tot   = nprod - 68'($signed(x_q));
  assign tmag  = tot[67] ? 64'(-tot) : 64'(tot);

  // floor((n-1)*d2/n) = d2 - ceil(d2/n)
  assign wsq     = d2_q - quo - 64'(rem != '0);
  assign sum_add = {1'b0, sum_q} + {1'b0, wsq};

  assign qs  = tneg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign qcl = (qs > SMAX) ? SMAX : ((qs < SMIN) ? SMIN : qs);
  assign q34 = $signed(quo[DIFF_W-1:0]);
  assign mean_new = ms + (dneg_q ? -q34 : q34);

  always_comb begin
    div_a = d2_q;
    div_b = nval;
    case (cmd_i.dsel)
      DS_D2_N:      begin div_a = d2_q;                div_b = nval;   end
      DS_M_N:       begin div_a = 64'(m_q);            div_b = nval;   end
      DS_TOT_NM1:   begin div_a = tot_q;               div_b = cnt_m1; end
      DS_SUM_CNT:   begin div_a = sum_q;               div_b = cnt_x;  end
      DS_SUM_CNTM1: begin div_a = sum_q;               div_b = cnt_m1; end
      default:      begin div_a = d2_q;                div_b = nval;   end
    endcase
  end
  assign div_start = (cmd_i.cmd == CMD_DIV);

  rmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mean_q <= '0;
      sum_q  <= '0;
    end else begin
      case (cmd_i.cmd)
        CMD_SIMPLE: begin
          if (op_q == OP_RECORD && cnt_q != '1) begin
            mean_q <= x_q;
            sum_q  <= '0;
            cnt_q  <= cnt_q + 1'b1;
          end else if ((op_q == OP_REMOVE && cnt_q != '0) || op_q == OP_CLEAR) begin
            mean_q <= '0;
            sum_q  <= '0;
            cnt_q  <= '0;
          end
        end
        CMD_REC_SUM:  sum_q <= sum_add[64] ? '1 : sum_add[63:0];
        CMD_REC_MEAN: begin
          mean_q <= SAMPLE_BITS'(mean_new);
          cnt_q  <= cnt_q + 1'b1;
        end
        CMD_REM_FIN: begin
          sum_q  <= (sum_q > wsq) ? sum_q - wsq : '0;
          mean_q <= prev_q;
          cnt_q  <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q     <= op_e'(operation_i);
      x_q      <= sample_i[SAMPLE_BITS-1:0];
      status_q <= ST_OK;
    end
    case (cmd_i.cmd)
      CMD_SIMPLE: begin
        if (op_q == OP_RECORD && cnt_q == '1) status_q <= ST_FULL;
        else if (op_q == OP_REMOVE && cnt_q == '0) status_q <= ST_EMPTY;
      end
      CMD_SQ_REC, CMD_SQ_REM: begin
        d2_q   <= sq[63:0];
        m_q    <= dmag[DIVISOR_W-1:0];
        dneg_q <= diff[DIFF_W-1];
      end
      CMD_TOTAL: begin
        tot_q  <= tmag;
        tneg_q <= tot[67];
      end
      CMD_REM_PREV:  prev_q <= SAMPLE_BITS'(qcl);
      CMD_POP_Q:     pop_q  <= quo;
      CMD_POP_ZERO:  pop_q  <= '0;
      CMD_SVAR_Q:    svar_q <= quo;
      CMD_SVAR_ZERO: svar_q <= '0;
      CMD_OUT: begin
        count_o           <= 32'(cnt_q);
        mean_o            <= 32'($signed(mean_q));
        sum_sq_dev_o      <= sum_q;
        pop_variance_o    <= pop_q;
        sample_variance_o <= svar_q;
        status_o          <= status_q;
      end
      default: ;
    endcase
  end

  assign sts_o.op       = op_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_lt2  = (cnt_q[COUNT_BITS-1:1] == '0);
  assign sts_o.cnt_full = (cnt_q == '1);
  assign sts_o.div_done = div_done;

endmodule

/* hdl/rmv_ctrl.sv */
// controller: sequences the datapath and runs both handshakes
// depends on rmv_pkg
module rmv_ctrl import rmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output logic load_o,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE,
    S_REC_D1, S_REC_W1, S_REC_D2, S_REC_W2,
    S_REM_D1, S_REM_W1, S_REM_SQ, S_REM_D2, S_REM_W2,
    S_POP, S_POP_GO, S_POP_W, S_SVAR, S_SVAR_W,
    S_FIN, S_DONE, S_SHOW
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic   ovalid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign load_o      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= '{cmd: CMD_NOP, dsel: DS_D2_N};
      ovalid_q <= 1'b0;
    end else begin
      cmd_t cmd_d;
      cmd_d = cmd_q;
      cmd_d.cmd = CMD_NOP;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DECIDE;
        S_DECIDE: begin
          if (sts_i.op == OP_RECORD && !sts_i.cnt_full && !sts_i.cnt_zero) begin
            cmd_d.cmd = CMD_SQ_REC;
            state_q   <= S_REC_D1;
          end else if (sts_i.op == OP_REMOVE && !sts_i.cnt_lt2) begin
            cmd_d.cmd = CMD_TOTAL;
            state_q   <= S_REM_D1;
          end else begin
            cmd_d.cmd = CMD_SIMPLE;
            state_q   <= S_POP;
          end
        end
        S_REC_D1: begin
          cmd_d   = '{cmd: CMD_DIV, dsel: DS_D2_N};
          state_q <= S_REC_W1;
        end
        S_REC_W1: if (sts_i.div_done) begin
          cmd_d.cmd = CMD_REC_SUM;
          state_q   <= S_REC_D2;
        end
        S_REC_D2: begin
          cmd_d   = '{cmd: CMD_DIV, dsel: DS_M_N};
          state_q <= S_REC_W2;
        end
        S_REC_W2: if (sts_i.div_done) begin
          cmd_d.cmd = CMD_REC_MEAN;
          state_q   <= S_POP;
        end
        S_REM_D1: begin
          cmd_d   = '{cmd: CMD_DIV, dsel: DS_TOT_NM1};
          state_q <= S_REM_W1;
        end
        S_REM_W1: if (sts_i.div_done) begin
          cmd_d.cmd = CMD_REM_PREV;
          state_q   <= S_REM_SQ;
        end
        S_REM_SQ: begin
          cmd_d.cmd = CMD_SQ_REM;
          state_q   <= S_REM_D2;
        end
        S_REM_D2: begin
          cmd_d   = '{cmd: CMD_DIV, dsel: DS_D2_N};
          state_q <= S_REM_W2;
        end
        S_REM_W2: if (sts_i.div_done) begin
          cmd_d.cmd = CMD_REM_FIN;
          state_q   <= S_POP;
        end
        // lets the last state update settle before the variances
        S_POP: state_q <= S_POP_GO;
        S_POP_GO: begin
          if (sts_i.cnt_zero) begin
            cmd_d.cmd = CMD_POP_ZERO;
            state_q   <= S_SVAR;
          end else begin
            cmd_d   = '{cmd: CMD_DIV, dsel: DS_SUM_CNT};
            state_q <= S_POP_W;
          end
        end
        S_POP_W: if (sts_i.div_done) begin
          cmd_d.cmd = CMD_POP_Q;
          state_q   <= S_SVAR;
        end
        S_SVAR: begin
          if (sts_i.cnt_lt2) begin
            cmd_d.cmd = CMD_SVAR_ZERO;
            state_q   <= S_FIN;
          end else begin
            cmd_d   = '{cmd: CMD_DIV, dsel: DS_SUM_CNTM1};
            state_q <= S_SVAR_W;
          end
        end
        S_SVAR_W: if (sts_i.div_done) begin
          cmd_d.cmd = CMD_SVAR_Q;
          state_q   <= S_FIN;
        end
        S_FIN: state_q <= S_DONE;
        // wait until the output register is free
        S_DONE: if (!ovalid_q || !out_stall_i) begin
          cmd_d.cmd = CMD_OUT;
          state_q   <= S_SHOW;
        end
        S_SHOW: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      cmd_q <= cmd_d;
    end
  end

endmodule

/* hdl/running_mean_variance.sv */
// channel  | valid        | stall        | payload
// request  | in_valid_i   | in_stall_o   | operation_i, sample_i
// result   | out_valid_o  | out_stall_i  | count_o, mean_o, sum_sq_dev_o, pop_variance_o,
//          |              |              | sample_variance_o, status_o
//
// one request at a time; all divisions run on the single shared bit-serial divider: two
// update divisions for a record or removal, then one for each variance that is not zero by
// count; clear, no-op, errors, a first sample and the removal of the only sample skip the
// update divisions
// asynchronous active-low reset empties the statistics; no clearing pass
// the next request is taken while a result still waits in the output register
// top level of the running mean and variance block
// depends on rmv_pkg, rmv_ctrl, rmv_dp
module running_mean_variance import rmv_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] count_o,
  output logic [31:0] mean_o,
  output logic [63:0] sum_sq_dev_o,
  output logic [63:0] pop_variance_o,
  output logic [63:0] sample_variance_o,
  output logic [1:0]  status_o
);

  sts_t sts;
  cmd_t cmd;
  logic load;

  rmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .load_o      (load),
    .cmd_o       (cmd)
  );

  rmv_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (load),
    .operation_i       (operation_i),
    .sample_i          (sample_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .count_o           (count_o),
    .mean_o            (mean_o),
    .sum_sq_dev_o      (sum_sq_dev_o),
    .pop_variance_o    (pop_variance_o),
    .sample_variance_o (sample_variance_o),
    .status_o          (status_o)
  );

endmodule

/* hdl/rmv_chk.sv */
// port-level checks for the running mean and variance block, with its bind
// depends only on the top-level ports
module rmv_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] count_o,
  input logic [31:0] mean_o,
  input logic [63:0] sum_sq_dev_o,
  input logic [63:0] pop_variance_o,
  input logic [63:0] sample_variance_o,
  input logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_empty_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_o == 32'd0 |->
      mean_o == 32'd0 && sum_sq_dev_o == 64'd0 && pop_variance_o == 64'd0)
    else $error("empty set with nonzero statistics");

  a_svar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_o == 32'd0 || count_o == 32'd1) |-> sample_variance_o == 64'd0)
    else $error("sample variance nonzero below two samples");

endmodule

bind running_mean_variance rmv_chk u_rmv_chk (.*);

/* tb/sv/tb.sv */
// self-checking testbench for running_mean_variance: directed table, then random requests
// depends on rmv_pkg and running_mean_variance; predicts each result and checks it in order
module tb;
  import rmv_pkg::*;

  typedef struct {
    bit [31:0] count;
    bit [31:0] mean;
    bit [63:0] ssq;
    bit [63:0] pop;
    bit [63:0] svar;
    status_e   status;
  } stats_t;

  typedef struct {
    op_e       op;
    bit [31:0] sample;
    bit        known;
    stats_t    res;
  } row_t;

  localparam longint SMAX = 64'sh7fff_ffff;
  localparam longint SMIN = -64'sh8000_0000;
  localparam bit [63:0] CNT_FULL = 64'hffff_ffff;
  localparam stats_t ZERO = '{0, 0, 0, 0, 0, ST_OK};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_CLEAR;
  logic [31:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] count_o, mean_o;
  logic [63:0] sum_sq_dev_o, pop_variance_o, sample_variance_o;
  logic [1:0]  status_o;

  running_mean_variance u_top (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  bit [63:0] n_held;
  longint    avg;
  bit [63:0] sq_sum;
  stats_t    pending[$];
  bit [31:0] recorded[$];
  int        errors = 0;
  int        send_idle = 0, recv_idle = 0;

  function automatic longint div_toward_zero(longint num, bit [63:0] den);
    bit [63:0] mag;
    mag = (num < 0) ? -num : num;
    mag = mag / den;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // floor((n-1)*d2/n)
  function automatic bit [63:0] weighted_sq(bit [63:0] d2, bit [63:0] n);
    return d2 - (d2 / n + ((d2 % n) != 0));
  endfunction

  function automatic stats_t update_stats(op_e op, bit [31:0] raw);
    stats_t    r;
    longint    x, d, prev;
    bit [63:0] m, inc;
    x = longint'(signed'(raw));
    r.status = ST_OK;
    case (op)
      OP_RECORD: begin
        if (n_held >= CNT_FULL) begin
          r.status = ST_FULL;
        end else if (n_held == 0) begin
          avg = x;
          sq_sum = 0;
          n_held = 1;
        end else begin
          n_held++;
          d = x - avg;
          m = (d < 0) ? -d : d;
          inc = weighted_sq(m * m, n_held);
          sq_sum = (sq_sum > ~inc) ? '1 : sq_sum + inc;
          avg += div_toward_zero(d, n_held);
        end
      end
      OP_REMOVE: begin
        if (n_held == 0) begin
          r.status = ST_EMPTY;
        end else if (n_held == 1) begin
          n_held = 0;
          avg = 0;
          sq_sum = 0;
        end else begin
          prev = div_toward_zero(longint'(n_held) * avg - x, n_held - 1);
          if (prev > SMAX) prev = SMAX;
          if (prev < SMIN) prev = SMIN;
          d = x - prev;
          m = (d < 0) ? -d : d;
          inc = weighted_sq(m * m, n_held);
          sq_sum = (sq_sum > inc) ? sq_sum - inc : 0;
          avg = prev;
          n_held--;
        end
      end
      OP_CLEAR: begin
        n_held = 0;
        avg = 0;
        sq_sum = 0;
      end
      default: ;
    endcase
    r.count = n_held[31:0];
    r.mean = avg[31:0];
    r.ssq = sq_sum;
    r.pop = (n_held == 0) ? 0 : sq_sum / n_held;
    r.svar = (n_held < 2) ? 0 : sq_sum / (n_held - 1);
    return r;
  endfunction

  // drive one request; returns at the edge that takes it
  task automatic send_request(op_e op, bit [31:0] raw, bit known, stats_t typed);
    stats_t r;
    bit     taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    r = update_stats(op, raw);
    if (known) r = typed;
    in_valid_i <= 1'b1;
    operation_i <= op;
    sample_i <= raw;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) pending.push_back(r);
      @(posedge clk_i);
    end while (!taken);
    if (op == OP_RECORD) recorded.push_back(raw);
    if (op == OP_CLEAR) recorded.delete();
  endtask

  task automatic check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle);

  always @(negedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending.pop_front();
        check_field("count", e.count, count_o);
        check_field("mean", e.mean, mean_o);
        check_field("sum_sq_dev", e.ssq, sum_sq_dev_o);
        check_field("pop_variance", e.pop, pop_variance_o);
        check_field("sample_variance", e.svar, sample_variance_o);
        check_field("status", e.status, status_o);
      end
    end
  end

  row_t dir_rows[] = '{
    '{OP_REMOVE, 32'h0000_0000, 1, '{0, 0, 0, 0, 0, ST_EMPTY}},
    '{OP_NONE,   32'hffff_ffff, 1, ZERO},
    '{OP_RECORD, 32'h7fff_ffff, 1, '{1, 32'h7fff_ffff, 0, 0, 0, ST_OK}},
    '{OP_RECORD, 32'h8000_0000, 0, ZERO},
    '{OP_RECORD, 32'h0000_0000, 0, ZERO},
    '{OP_RECORD, 32'hffff_ffff, 0, ZERO},
    '{OP_REMOVE, 32'h8000_0000, 0, ZERO},
    '{OP_REMOVE, 32'h0000_3039, 0, ZERO},
    '{OP_NONE,   32'h1234_5678, 0, ZERO},
    '{OP_CLEAR,  32'h5555_aaaa, 1, ZERO},
    '{OP_RECORD, 32'h8000_0000, 1, '{1, 32'h8000_0000, 0, 0, 0, ST_OK}},
    '{OP_RECORD, 32'h7fff_ffff, 0, ZERO},
    '{OP_REMOVE, 32'h7fff_ffff, 0, ZERO},
    '{OP_REMOVE, 32'h8000_0000, 1, ZERO},
    '{OP_REMOVE, 32'h0000_0001, 1, '{0, 0, 0, 0, 0, ST_EMPTY}},
    '{OP_RECORD, 32'h0001_0000, 0, ZERO},
    '{OP_RECORD, 32'h0002_0000, 0, ZERO},
    '{OP_RECORD, 32'h0003_0000, 0, ZERO},
    '{OP_REMOVE, 32'h0002_0000, 0, ZERO},
    '{OP_REMOVE, 32'h8000_0000, 0, ZERO},
    '{OP_CLEAR,  32'h0000_0000, 1, ZERO}
  };

  function automatic bit [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return 32'(signed'($urandom_range(20000)) - 10000) <<< $urandom_range(8);
    endcase
  endfunction

  initial begin
    int        pick, phase;
    op_e       op;
    bit [31:0] raw;
    n_held = 0;
    avg = 0;
    sq_sum = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].known, dir_rows[i].res);
    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
      recv_idle = (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
      for (int k = 0; k < 140; ) begin
        pick = $urandom_range(99);
        raw = rand_sample();
        if (pick < 55) begin
          op = OP_RECORD;
        end else if (pick < 80 && recorded.size() > 0) begin
          // mostly take back a value that really was recorded
          op = OP_REMOVE;
          pick = $urandom_range(recorded.size() - 1);
          raw = recorded[pick];
          recorded.delete(pick);
        end else if (pick < 92) begin
          op = OP_REMOVE;
        end else if (pick < 97) begin
          op = OP_CLEAR;
        end else begin
          op = OP_NONE;
        end
        send_request(op, raw, 1'b0, ZERO);
        if (op != OP_NONE) k++;
      end
    end
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/rmv_pkg.sv
hdl/rmv_div.sv
hdl/rmv_dp.sv
hdl/rmv_ctrl.sv
hdl/running_mean_variance.sv
hdl/rmv_chk.sv
tb/sv/tb.sv
